/* hdl/tcr_pkg.sv */
// ----------------------------------------------------------------------------
// tcr_pkg
// Shared types and codes of the touch coordinate remapper: register indexes,
// flag bit positions, result status codes and the per-axis setup bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package tcr_pkg;

	// configuration register indexes
	localparam logic [2:0] CFG_SRC_X = 3'd0;
	localparam logic [2:0] CFG_SRC_Y = 3'd1;
	localparam logic [2:0] CFG_DST_X = 3'd2;
	localparam logic [2:0] CFG_DST_Y = 3'd3;
	localparam logic [2:0] CFG_SRC_FLAGS = 3'd4;
	localparam logic [2:0] CFG_DST_FLAGS = 3'd5;

	// flag bit positions
	localparam int FLAG_HORZ = 0;
	localparam int FLAG_VERT = 1;
	localparam int FLAG_SWAP = 2;
	localparam int FLAG_USED = 3;

	// result status
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_OFF   = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	// static setup of one axis, taken from the configuration registers
	typedef struct packed {
		logic signed [15:0] src_lo;
		logic signed [15:0] src_hi;
		logic signed [15:0] dst_lo;
		logic signed [15:0] dst_hi;
		logic               flip;
	} axis_cfg_t;

endpackage

`default_nettype wire

/* hdl/tcr_div_stage.sv */
// ----------------------------------------------------------------------------
// tcr_div_stage
// One registered step of the restoring divider: settles one quotient bit.
// ----------------------------------------------------------------------------
`default_nettype none

module tcr_div_stage #(
	parameter int W   = 26,
	parameter int FW  = 10,
	parameter int BIT = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          vld,
	input  logic          ok,
	input  logic [W-1:0]  rem,
	input  logic [FW-1:0] quo,
	input  logic [15:0]   span,
	output logic          vld_q,
	output logic          ok_q,
	output logic [W-1:0]  rem_q,
	output logic [FW-1:0] quo_q
);

	logic [W-1:0] dsh;
	logic         ge;

	// trial subtract of the divisor aligned to this bit
	assign dsh = W'(span) << BIT;
	assign ge  = (rem >= dsh);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld;
		end
	end

	always_ff @(posedge clk) begin
		ok_q  <= ok;
		rem_q <= ge ? (rem - dsh) : rem;
		quo_q <= quo | (FW'(ge) << BIT);
	end

endmodule

`default_nettype wire

/* hdl/tcr_axis.sv */
// ----------------------------------------------------------------------------
// tcr_axis
// Pipeline of one axis: range check, fraction by a bit-per-stage divider,
// orientation flip, scaling into the screen span with a reciprocal divide.
// ----------------------------------------------------------------------------
`default_nettype none

module tcr_axis import tcr_pkg::*; #(
	parameter int SCALE_STEPS = 1000
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  logic signed [15:0] v,
	input  axis_cfg_t          cfg,
	output logic               res_vld,
	output logic signed [15:0] res,
	output logic               res_bad
);

	localparam int FW = $clog2(SCALE_STEPS + 1);  // fraction bits
	localparam int W  = FW + 16;                   // product / numerator bits
	localparam logic [FW-1:0] STEPS = FW'(SCALE_STEPS);
	// floor(2^W / steps); error of the estimate stays below one
	localparam logic [W-1:0] RECIP = W'((64'd1 << W) / 64'(SCALE_STEPS));

	// the user must keep the spans static while items are in flight; the block does not enforce it
	logic [15:0] src_span;
	logic [15:0] dst_span;
	logic        dst_ok;

	assign src_span = 16'(cfg.src_hi - cfg.src_lo);
	assign dst_span = 16'(cfg.dst_hi - cfg.dst_lo);
	assign dst_ok   = (cfg.dst_hi > cfg.dst_lo);

	// stage 1: range check and offset from the panel minimum
	logic               ok_w;
	logic signed [16:0] rel_w;

	assign ok_w  = (v >= cfg.src_lo) && (v <= cfg.src_hi) && (cfg.src_hi > cfg.src_lo);
	assign rel_w = 17'(v) - 17'(cfg.src_lo);

	logic        vld_s1, ok_s1;
	logic [15:0] rel_s1;

	// stage 2: numerator
	logic         vld_s2, ok_s2;
	logic [W-1:0] num_s2;

	// divider chain
	logic          vld_d [FW+1];
	logic          ok_d  [FW+1];
	logic [W-1:0]  rem_d [FW];
	logic [FW-1:0] quo_d [FW+1];

	// stages after the divider
	logic          vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic          ok_s3, ok_s4, ok_s5, ok_s6, ok_s7;
	logic [FW-1:0] frac_s3;
	logic [W-1:0]  prod_s4, prod_s5, prod_s6;
	logic [15:0]   qe_s5, qe_s6, q_s7;
	logic [W-1:0]  qs_s6;
	logic signed [15:0] res_s8;
	logic          bad_s8;

	logic [2*W-1:0]     est_w;
	logic [W-1:0]       rem_w;
	logic signed [16:0] o_w;

	assign est_w = (2*W)'(prod_s4) * (2*W)'(RECIP);
	assign rem_w = prod_s6 - qs_s6;
	assign o_w   = 17'(cfg.dst_lo) + $signed({1'b0, q_s7});

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			vld_s1 <= take;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_d[FW];
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		ok_s1   <= ok_w;
		rel_s1  <= rel_w[15:0];

		ok_s2   <= ok_s1;
		num_s2  <= W'(rel_s1) * W'(STEPS);

		// flip the fraction when orientations differ
		ok_s3   <= ok_d[FW];
		frac_s3 <= cfg.flip ? (STEPS - quo_d[FW]) : quo_d[FW];

		ok_s4   <= ok_s3;
		prod_s4 <= W'(frac_s3) * W'(dst_span);

		// quotient estimate, low by at most one
		ok_s5   <= ok_s4;
		prod_s5 <= prod_s4;
		qe_s5   <= est_w[W +: 16];

		ok_s6   <= ok_s5;
		prod_s6 <= prod_s5;
		qe_s6   <= qe_s5;
		qs_s6   <= W'(qe_s5) * W'(STEPS);

		// correction step
		ok_s7   <= ok_s6;
		q_s7    <= qe_s6 + 16'(rem_w >= W'(STEPS));

		// place into screen range; minus one counts as out of range
		res_s8  <= o_w[15:0];
		bad_s8  <= !ok_s7 || !dst_ok || (o_w[15:0] == 16'hFFFF);
	end

	assign vld_d[0] = vld_s2;
	assign ok_d[0]  = ok_s2;
	assign rem_d[0] = num_s2;
	assign quo_d[0] = '0;

	// one quotient bit per stage, most significant first
	for (genvar k = 0; k < FW; k++) begin : g_div
		if (k < FW - 1) begin : g_mid
			tcr_div_stage #(.W(W), .FW(FW), .BIT(FW - 1 - k)) u_stage (
				.clk   (clk),
				.arst_n(arst_n),
				.vld   (vld_d[k]),
				.ok    (ok_d[k]),
				.rem   (rem_d[k]),
				.quo   (quo_d[k]),
				.span  (src_span),
				.vld_q (vld_d[k+1]),
				.ok_q  (ok_d[k+1]),
				.rem_q (rem_d[k+1]),
				.quo_q (quo_d[k+1])
			);
		end else begin : g_last
			tcr_div_stage #(.W(W), .FW(FW), .BIT(FW - 1 - k)) u_stage (
				.clk   (clk),
				.arst_n(arst_n),
				.vld   (vld_d[k]),
				.ok    (ok_d[k]),
				.rem   (rem_d[k]),
				.quo   (quo_d[k]),
				.span  (src_span),
				.vld_q (vld_d[k+1]),
				.ok_q  (ok_d[k+1]),
				.rem_q (),
				.quo_q (quo_d[k+1])
			);
		end
	end

	assign res_vld = vld_s8;
	assign res     = res_s8;
	assign res_bad = bad_s8;

endmodule

`default_nettype wire

/* hdl/touch_coordinate_remapper_core.sv */
// ----------------------------------------------------------------------------
// touch_coordinate_remapper_core
// Maps a raw panel touch point onto screen coordinates, one point per cycle.
//
// Channel   Direction  Signals                    Transfer
// input     in         start, busy, x_in, y_in    edge with start high, busy low
// result    out        done, x_out, y_out, status one cycle with done high
// config    in         cfg_we, cfg_idx, cfg_wdata edge with cfg_we high
//
// A point is taken every cycle; busy stays low. Each result passes through
// the input register, the numerator register, the fraction divider with
// one quotient bit per stage and the back stages to the output register.
// Reset clears the valid bits and the configuration registers and empties the pipeline; no clearing pass.
// The receiver takes every result as it appears, so nothing stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_coordinate_remapper_core import tcr_pkg::*; #(
	parameter int SCALE_STEPS = 1000
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] x_in,
	input  logic signed [15:0] y_in,
	output logic               done,
	output logic signed [15:0] x_out,
	output logic signed [15:0] y_out,
	output logic [1:0]         status,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_idx,
	input  logic [31:0]        cfg_wdata
);

	logic [31:0] src_x_q, src_y_q, dst_x_q, dst_y_q;
	logic [3:0]  src_flags_q, dst_flags_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_x_q     <= '0;
			src_y_q     <= '0;
			dst_x_q     <= '0;
			dst_y_q     <= '0;
			src_flags_q <= '0;
			dst_flags_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_SRC_X:     src_x_q     <= cfg_wdata;
				CFG_SRC_Y:     src_y_q     <= cfg_wdata;
				CFG_DST_X:     dst_x_q     <= cfg_wdata;
				CFG_DST_Y:     dst_y_q     <= cfg_wdata;
				CFG_SRC_FLAGS: src_flags_q <= cfg_wdata[3:0];
				CFG_DST_FLAGS: dst_flags_q <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	// per-axis setup
	logic [3:0] diff;
	axis_cfg_t  cfg_x, cfg_y;
	logic       take;

	assign diff = src_flags_q ^ dst_flags_q;

	assign cfg_x = '{src_lo: src_x_q[15:0], src_hi: src_x_q[31:16],
	                 dst_lo: dst_x_q[15:0], dst_hi: dst_x_q[31:16],
	                 flip: diff[FLAG_HORZ]};
	assign cfg_y = '{src_lo: src_y_q[15:0], src_hi: src_y_q[31:16],
	                 dst_lo: dst_y_q[15:0], dst_hi: dst_y_q[31:16],
	                 flip: diff[FLAG_VERT]};

	// fully pipelined: a point is taken on every cycle
	assign busy = 1'b0;
	assign take = start && !busy;

	logic               vx, vy, bad_x, bad_y;
	logic signed [15:0] ox, oy;

	tcr_axis #(.SCALE_STEPS(SCALE_STEPS)) u_axis_x (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.v      (x_in),
		.cfg    (cfg_x),
		.res_vld(vx),
		.res    (ox),
		.res_bad(bad_x)
	);

	tcr_axis #(.SCALE_STEPS(SCALE_STEPS)) u_axis_y (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.v      (y_in),
		.cfg    (cfg_y),
		.res_vld(vy),
		.res    (oy),
		.res_bad(bad_y)
	);

	// status, field zeroing and axis swap
	logic               in_use;
	status_t            status_w;
	logic signed [15:0] xr_w, yr_w;

	assign in_use = src_flags_q[FLAG_USED] && dst_flags_q[FLAG_USED];

	always_comb begin
		status_w = ST_OK;
		xr_w     = '0;
		yr_w     = '0;
		priority if (!in_use) begin
			status_w = ST_OFF;
		end else if (bad_x || bad_y) begin
			status_w = ST_RANGE;
		end else if (diff[FLAG_SWAP]) begin
			xr_w = oy;
			yr_w = ox;
		end else begin
			xr_w = ox;
			yr_w = oy;
		end
	end

	logic               done_q;
	status_t            status_q;
	logic signed [15:0] x_q, y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vx && vy;
		end
	end

	always_ff @(posedge clk) begin
		status_q <= status_w;
		x_q      <= xr_w;
		y_q      <= yr_w;
	end

	assign done   = done_q;
	assign x_out  = x_q;
	assign y_out  = y_q;
	assign status = status_q;

endmodule

`default_nettype wire

/* hdl/tcr_checker.sv */
// ----------------------------------------------------------------------------
// tcr_checker
// Port-level checks of the remapper: fixed latency, zeroed fields on
// failure, no minus-one coordinate on success.
// ----------------------------------------------------------------------------
`default_nettype none

module tcr_checker import tcr_pkg::*; #(
	parameter int SCALE_STEPS = 1000
) (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic signed [15:0] x_out,
	input logic signed [15:0] y_out,
	input logic [1:0]         status
);

	// input register, numerator, divider bits, six back stages, output
	localparam int LAT = $clog2(SCALE_STEPS + 1) + 9;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("result missing after a point transfer");

	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without a matching point transfer");

	a_zeroed: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != ST_OK) |-> (x_out == 16'sd0) && (y_out == 16'sd0))
		else $error("coordinates not zero on a failed point");

	a_no_minus_one: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_OK) |-> (x_out != -16'sd1) && (y_out != -16'sd1))
		else $error("minus one reported as a valid coordinate");

endmodule

bind touch_coordinate_remapper_core tcr_checker #(.SCALE_STEPS(SCALE_STEPS)) u_tcr_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done),
	.x_out (x_out),
	.y_out (y_out),
	.status(status)
);

`default_nettype wire

/* bench/tb_touch_coordinate_remapper_core.sv */
// ----------------------------------------------------------------------------
// tb_touch_coordinate_remapper_core
// Self-checking bench for the touch coordinate remapper. Panel and screen
// ranges and orientation flags are loaded while the pipeline is empty. Touch
// points are then pushed through with random gaps. Every point is mapped by a
// local predictor when it is taken, and each result strobe is compared field
// by field with the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb_touch_coordinate_remapper_core;
	timeunit 1ns;
	timeprecision 1ps;

	import tcr_pkg::*;

	localparam int STEPS = 1000;

	// indexes past the last register, decoded to nothing
	localparam logic [2:0] CFG_SPARE_A = 3'd6;
	localparam logic [2:0] CFG_SPARE_B = 3'd7;

	localparam logic [3:0] F_HORZ = 4'(1 << FLAG_HORZ);
	localparam logic [3:0] F_VERT = 4'(1 << FLAG_VERT);
	localparam logic [3:0] F_SWAP = 4'(1 << FLAG_SWAP);
	localparam logic [3:0] F_USED = 4'(1 << FLAG_USED);

	typedef struct {
		logic signed [15:0] x;
		logic signed [15:0] y;
		status_t            status;
	} screen_point_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic signed [15:0] x_in = '0;
	logic signed [15:0] y_in = '0;
	logic               done;
	logic signed [15:0] x_out;
	logic signed [15:0] y_out;
	logic [1:0]         status;
	logic               cfg_we = 1'b0;
	logic [2:0]         cfg_idx = '0;
	logic [31:0]        cfg_wdata = '0;

	// local copy of the register file
	logic [31:0] range_reg [4] = '{default: '0};
	logic [3:0]  src_flg = '0;
	logic [3:0]  dst_flg = '0;

	screen_point_t points_due [$];
	int errors = 0;

	touch_coordinate_remapper_core #(
		.SCALE_STEPS(STEPS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.x_in     (x_in),
		.y_in     (y_in),
		.done     (done),
		.x_out    (x_out),
		.y_out    (y_out),
		.status   (status),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	always #10 clk = ~clk;

	initial begin
		#(20_000_000);
		$display("Verification failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------
	function automatic logic [31:0] pack_lim(int lo, int hi);
		return {hi[15:0], lo[15:0]};
	endfunction

	function automatic int lim_lo(logic [31:0] lim);
		return int'($signed(lim[15:0]));
	endfunction

	function automatic int lim_hi(logic [31:0] lim);
		return int'($signed(lim[31:16]));
	endfunction

	// truncated position within the panel range, -1 when outside
	function automatic int panel_fraction(int v, logic [31:0] lim, logic flip);
		int lo, hi, f;
		lo = lim_lo(lim);
		hi = lim_hi(lim);
		if (v < lo || v > hi || hi <= lo)
			return -1;
		f = ((v - lo) * STEPS) / (hi - lo);
		return flip ? STEPS - f : f;
	endfunction

	// fraction placed into the screen range, -1 when invalid
	function automatic int screen_place(int f, logic [31:0] lim);
		int lo, hi, o;
		lo = lim_lo(lim);
		hi = lim_hi(lim);
		if (f < 0 || hi <= lo)
			return -1;
		o = lo + (f * (hi - lo)) / STEPS;
		return (o > hi) ? -1 : o;
	endfunction

	function automatic screen_point_t map_point(logic signed [15:0] x, logic signed [15:0] y);
		screen_point_t p;
		logic [3:0] diff;
		int ox, oy;
		p.x = '0;
		p.y = '0;
		p.status = ST_OK;
		diff = src_flg ^ dst_flg;
		if (!src_flg[FLAG_USED] || !dst_flg[FLAG_USED]) begin
			p.status = ST_OFF;
			return p;
		end
		ox = screen_place(panel_fraction(int'(x), range_reg[CFG_SRC_X[1:0]], diff[FLAG_HORZ]),
			range_reg[CFG_DST_X[1:0]]);
		oy = screen_place(panel_fraction(int'(y), range_reg[CFG_SRC_Y[1:0]], diff[FLAG_VERT]),
			range_reg[CFG_DST_Y[1:0]]);
		// minus one doubles as the invalid marker, even inside the screen range
		if (ox == -1 || oy == -1) begin
			p.status = ST_RANGE;
			return p;
		end
		if (diff[FLAG_SWAP]) begin
			p.x = oy[15:0];
			p.y = ox[15:0];
		end else begin
			p.x = ox[15:0];
			p.y = oy[15:0];
		end
		return p;
	endfunction

	// ------------------------------------------------------------------
	// result checking
	// ------------------------------------------------------------------
	task automatic report_mismatch(input string what);
		errors++;
		$display("MISMATCH @%0t: %s", $time, what);
	endtask

	always @(posedge clk) begin : result_check
		screen_point_t want;
		if (arst_n && done) begin
			if (points_due.size() == 0) begin
				report_mismatch($sformatf("result with nothing pending x=%0d y=%0d st=%0d",
					x_out, y_out, status));
			end else begin
				want = points_due.pop_front();
				if (x_out !== want.x)
					report_mismatch($sformatf("x_out %0d, predicted %0d", x_out, want.x));
				if (y_out !== want.y)
					report_mismatch($sformatf("y_out %0d, predicted %0d", y_out, want.y));
				if (status !== want.status)
					report_mismatch($sformatf("status %0d, predicted %0d",
						status, want.status));
			end
		end
	end

	// ------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------
	// leaves cfg_we high so back-to-back writes never pulse it low
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		case (idx)
			CFG_SRC_X, CFG_SRC_Y, CFG_DST_X, CFG_DST_Y: range_reg[idx[1:0]] = data;
			CFG_SRC_FLAGS: src_flg = data[3:0];
			CFG_DST_FLAGS: dst_flg = data[3:0];
			default: ;
		endcase
	endtask

	task automatic end_writes();
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// full setup; flag writes carry junk above bit 3, plus one dead-index write
	task automatic load_setup(input logic [31:0] sx, input logic [31:0] sy,
			input logic [31:0] dx, input logic [31:0] dy,
			input logic [3:0] sf, input logic [3:0] df);
		write_reg(CFG_SRC_X, sx);
		write_reg(CFG_SRC_Y, sy);
		write_reg(CFG_DST_X, dx);
		write_reg(CFG_DST_Y, dy);
		write_reg(CFG_SRC_FLAGS, {28'($urandom()), sf});
		write_reg(CFG_DST_FLAGS, {28'($urandom()), df});
		write_reg($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B, $urandom());
		end_writes();
	endtask

	// start stays high afterwards; the caller lowers it or sends again
	task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y);
		start <= 1'b1;
		x_in <= x;
		y_in <= y;
		do
			@(posedge clk);
		while (busy);
		points_due.push_back(map_point(x, y));
	endtask

	task automatic pause_input(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// hold off until every pending result has come back
	task automatic drain();
		start <= 1'b0;
		while (points_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// random sources
	// ------------------------------------------------------------------
	function automatic int gap_cycles();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(3, 1);
		if (r < 97)
			return $urandom_range(12, 4);
		return $urandom_range(60, 20);
	endfunction

	// mostly valid ranges; some full span, some one step wide, some empty/inverted
	function automatic logic [31:0] rand_limits();
		int lo, hi, r;
		r = $urandom_range(99);
		lo = int'($urandom_range(65534)) - 32768;
		if (r < 8)
			return pack_lim(-32768, 32767);
		if (r < 16)
			return pack_lim(lo, lo + 1);
		if (r < 26) begin
			hi = int'($urandom_range(65535)) - 32768;
			return (hi > lo) ? pack_lim(hi, lo) : pack_lim(lo, hi);
		end
		hi = lo + int'($urandom_range(32767 - lo, 1));
		return pack_lim(lo, hi);
	endfunction

	// coordinate mostly inside the panel range, some on its edges, some anywhere
	function automatic logic signed [15:0] rand_coord(logic [31:0] lim);
		int lo, hi, r, v;
		lo = lim_lo(lim);
		hi = lim_hi(lim);
		r = $urandom_range(99);
		if (r < 12 || hi <= lo) begin
			v = int'($urandom_range(65535)) - 32768;
		end else if (r < 24) begin
			case ($urandom_range(3))
				0: v = lo - 1;
				1: v = lo;
				2: v = hi;
				default: v = hi + 1;
			endcase
		end else begin
			v = lo + int'($urandom_range(hi - lo));
		end
		if (v < -32768)
			v = -32768;
		if (v > 32767)
			v = 32767;
		return v[15:0];
	endfunction

	function automatic logic [3:0] rand_flags();
		return {($urandom_range(15) != 0), 3'($urandom())};
	endfunction

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	// registers still at reset, then only one side in use
	task automatic test_reset_state();
		send_point(-32768, 32767);
		send_point(0, 0);
		drain();
		write_reg(CFG_SRC_FLAGS, F_USED);
		end_writes();
		send_point(100, 100);
		drain();
		write_reg(CFG_SRC_FLAGS, '0);
		write_reg(CFG_DST_FLAGS, F_USED);
		end_writes();
		send_point(100, 100);
		drain();
	endtask

	// plain panel-to-screen mapping with range edges and field extremes
	task automatic test_nominal_mapping();
		load_setup(pack_lim(0, 4095), pack_lim(0, 4095), pack_lim(0, 799), pack_lim(0, 479),
			F_USED, F_USED);
		send_point(0, 0);
		send_point(4095, 4095);
		send_point(2047, 100);
		send_point(-1, 0);
		send_point(4096, 0);
		send_point(0, -32768);
		send_point(0, 32767);
		drain();
	endtask

	// each orientation flag and the axis swap on its own
	task automatic test_orientation();
		write_reg(CFG_SRC_FLAGS, F_USED | F_HORZ);
		end_writes();
		send_point(0, 4095);
		drain();
		write_reg(CFG_SRC_FLAGS, F_USED);
		write_reg(CFG_DST_FLAGS, F_USED | F_VERT);
		end_writes();
		send_point(0, 0);
		drain();
		write_reg(CFG_SRC_FLAGS, F_USED | F_SWAP);
		write_reg(CFG_DST_FLAGS, F_USED);
		end_writes();
		send_point(100, 4000);
		drain();
	endtask

	// a mapped value of minus one is rejected even though it is on screen
	task automatic test_minus_one();
		write_reg(CFG_SRC_FLAGS, F_USED);
		write_reg(CFG_SRC_X, pack_lim(0, 20));
		write_reg(CFG_DST_X, pack_lim(-10, 10));
		end_writes();
		send_point(9, 0);
		send_point(10, 0);
		drain();
	endtask

	// empty panel range, then inverted screen range
	task automatic test_empty_ranges();
		write_reg(CFG_SRC_X, pack_lim(5, 5));
		end_writes();
		send_point(5, 0);
		drain();
		write_reg(CFG_SRC_X, pack_lim(0, 20));
		write_reg(CFG_DST_Y, pack_lim(10, -10));
		end_writes();
		send_point(10, 0);
		drain();
	endtask

	// junk above the flag bits and writes to dead indexes change nothing
	task automatic test_register_decode();
		write_reg(CFG_DST_Y, pack_lim(0, 479));
		write_reg(CFG_SRC_FLAGS, {28'hFFF_FFFF, F_USED});
		write_reg(CFG_SPARE_A, $urandom());
		write_reg(CFG_SPARE_B, $urandom());
		end_writes();
		send_point(3, 200);
		drain();
	endtask

	// widest possible ranges on both sides
	task automatic test_full_span();
		int i, g;
		load_setup(pack_lim(-32768, 32767), pack_lim(-32768, 32767),
			pack_lim(-32768, 32767), pack_lim(-32768, 32767),
			F_USED | 4'($urandom_range(7)), F_USED | 4'($urandom_range(7)));
		send_point(-32768, 32767);
		send_point(32767, -32768);
		for (i = 0; i < 100; i++) begin
			send_point(16'($urandom()), 16'($urandom()));
			if (i % 2 == 0) begin
				g = gap_cycles();
				if (g > 0)
					pause_input(g);
			end
		end
		drain();
	endtask

	// random setups, each followed by a run of points
	task automatic test_random_setups();
		int phase, i, g;
		bit burst;
		for (phase = 0; phase < 13; phase++) begin
			load_setup(rand_limits(), rand_limits(), rand_limits(), rand_limits(),
				rand_flags(), rand_flags());
			burst = (phase % 4 == 1);
			for (i = 0; i < 100; i++) begin
				send_point(rand_coord(range_reg[CFG_SRC_X[1:0]]),
					rand_coord(range_reg[CFG_SRC_Y[1:0]]));
				g = burst ? 0 : gap_cycles();
				if (g > 0)
					pause_input(g);
			end
			drain();
		end
	endtask

	// ------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_nominal_mapping();
		test_orientation();
		test_minus_one();
		test_empty_ranges();
		test_register_decode();
		test_full_span();
		test_random_setups();
		drain();
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
